### design/serial_frame_router_top_macros.svh
// Assertion macros for the serial frame router.
`ifndef SERIAL_FRAME_ROUTER_TOP_MACROS_SVH
`define SERIAL_FRAME_ROUTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/sfr_pkg.sv
// Types and constants shared by the serial frame router.
package sfr_pkg;

    localparam int MAX_RES  = 3;
    localparam int OQ_DEPTH = 4;

    localparam logic [7:0] ZERO_CHAR = 8'h30;

    typedef enum logic [0:0] {
        CFG_SYNC_VALUE = 1'b0,
        CFG_MAX_LENGTH = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_SYNC = 4'b0001,
        PH_DEST = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [1:0] source_port;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] dest_port;
        logic [7:0] tx_byte;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        t_phase     phase;
        logic [1:0] target;
        logic [7:0] left;
    } t_port_state;

    typedef struct packed {
        t_port_state               nxt;
        logic [1:0]                n_res;
        t_out_item [MAX_RES-1:0]   res;
    } t_parse_res;

endpackage

### design/sfr_parse.sv
// Per-port frame parser step: next state and result items for one byte.
module sfr_parse #(
    parameter int PORT_COUNT = 3
) (
    input  sfr_pkg::t_in_item    i_item,
    input  sfr_pkg::t_port_state i_state,
    input  logic [7:0]           i_sync_value,
    input  logic [7:0]           i_max_length,
    output sfr_pkg::t_parse_res  o_res
);

    logic [7:0] x;
    logic       src_ok;
    logic       is_sync;
    logic       dest_ok;
    logic       len_ok;

    assign x       = i_item.rx_byte;
    assign src_ok  = 32'(i_item.source_port) < PORT_COUNT;
    assign is_sync = (x == i_sync_value);
    assign dest_ok = (32'(x) < PORT_COUNT) && (x != {6'b0, i_item.source_port});
    assign len_ok  = (x != 8'd0) && (x <= i_max_length);

    always_comb begin
        o_res.nxt   = i_state;
        o_res.n_res = 2'd0;
        o_res.res[0] = '{dest_port: i_state.target, tx_byte: x, last_of_run: 1'b1};
        o_res.res[1] = '{dest_port: i_state.target, tx_byte: {6'b0, i_item.source_port},
                         last_of_run: 1'b0};
        o_res.res[2] = '{dest_port: i_state.target, tx_byte: x, last_of_run: 1'b1};
        if (src_ok) begin
            case (i_state.phase)
                sfr_pkg::PH_SYNC: begin
                    if (is_sync) o_res.nxt.phase = sfr_pkg::PH_DEST;
                end
                sfr_pkg::PH_DEST: begin
                    // port test wins over sync test
                    if (dest_ok) begin
                        o_res.nxt.target = x[1:0];
                        o_res.nxt.phase  = sfr_pkg::PH_LEN;
                    end
                end
                sfr_pkg::PH_LEN: begin
                    if (len_ok) begin
                        o_res.nxt.left  = x;
                        o_res.nxt.phase = sfr_pkg::PH_DATA;
                        o_res.n_res     = 2'd3;
                        o_res.res[0] = '{dest_port: i_state.target, tx_byte: i_sync_value,
                                         last_of_run: 1'b0};
                    end else if (is_sync) begin
                        o_res.nxt.phase = sfr_pkg::PH_DEST;
                    end
                end
                default: begin
                    if (is_sync) begin
                        o_res.nxt.phase = sfr_pkg::PH_DEST;
                    end else if (x != sfr_pkg::ZERO_CHAR && i_state.left != 8'd0) begin
                        o_res.nxt.left = i_state.left - 8'd1;
                        o_res.n_res    = 2'd1;
                    end
                end
            endcase
        end
    end

endmodule

### design/sfr_outq.sv
// Result queue: takes up to three requests per cycle, delivers one when popped.
module sfr_outq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [1:0]                          i_push_n,
    input  sfr_pkg::t_out_item [sfr_pkg::MAX_RES-1:0] i_push_item,
    input  logic                                i_pop,
    output sfr_pkg::t_out_item                  o_head,
    output logic [$clog2(sfr_pkg::OQ_DEPTH):0]  o_count
);

    localparam int AW = $clog2(sfr_pkg::OQ_DEPTH);

    sfr_pkg::t_out_item r_mem [sfr_pkg::OQ_DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [AW:0]   r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr + AW'(i_push_n);
        n_rptr  = r_rptr + AW'(i_pop);
        n_count = r_count + (AW+1)'(i_push_n) - (AW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < sfr_pkg::MAX_RES; k++) begin
            if (k < int'(i_push_n)) r_mem[r_wptr + AW'(k)] <= i_push_item[k];
        end
    end

    assign o_head  = r_mem[r_rptr];
    assign o_count = r_count;

endmodule

### design/serial_frame_router_top.sv
// Serial frame router top level: config registers, per-port state, result queue.
//
// Input channel (i_in_valid / o_in_stall / i_in_item) takes one received byte
// with the port it arrived on. Output channel (o_out_valid / i_out_stall /
// o_out_item) delivers one routed byte per request: destination port, byte,
// and last_of_run on the final result caused by an input byte.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 sync value,
// 1 max length); write only while the block is idle.
//
// Each byte is parsed in the cycle it is accepted; its results are written
// into the registered result queue and read from there. Throughput is one byte
// per cycle while o_in_stall is low. A valid header length byte makes three
// results, and the four-entry result queue then holds off input while they drain.
// Input stall comes from the registered queue fill only, so a stalled
// receiver backs up into o_in_stall once more than one result is queued.
//
// Reset: all port parsers go to the sync state with zero route and count,
// sync value returns to 170, max length to 64, and the queue empties.
`include "serial_frame_router_top_macros.svh"

module serial_frame_router_top #(
    parameter int PORT_COUNT = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sfr_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sfr_pkg::t_out_item o_out_item,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);

    localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int CW = $clog2(sfr_pkg::OQ_DEPTH) + 1;

    logic [7:0] r_sync_value;
    logic [7:0] r_max_length;

    sfr_pkg::t_port_state r_state [PORT_COUNT];
    sfr_pkg::t_port_state cur_state;
    sfr_pkg::t_parse_res  parse_res;

    logic          in_accept;
    logic          out_pop;
    logic [1:0]    push_n;
    logic [CW-1:0] q_count;
    logic [PW-1:0] src_idx;

    assign src_idx   = PW'(i_in_item.source_port);
    assign cur_state = r_state[src_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= 8'd170;
            r_max_length <= 8'd64;
        end else if (i_cfg_we) begin
            case (sfr_pkg::t_cfg_idx'(i_cfg_idx))
                sfr_pkg::CFG_SYNC_VALUE: r_sync_value <= i_cfg_data;
                sfr_pkg::CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sfr_parse #(.PORT_COUNT(PORT_COUNT)) u_parse (
        .i_item       (i_in_item),
        .i_state      (cur_state),
        .i_sync_value (r_sync_value),
        .i_max_length (r_max_length),
        .o_res        (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_state[p] <= '{phase: sfr_pkg::PH_SYNC, target: 2'd0, left: 8'd0};
            end
        end else if (in_accept && 32'(i_in_item.source_port) < PORT_COUNT) begin
            r_state[src_idx] <= parse_res.nxt;
        end
    end

    // room for a full header burst, judged on the registered fill level
    assign o_in_stall = q_count > CW'(sfr_pkg::OQ_DEPTH - sfr_pkg::MAX_RES);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign push_n     = in_accept ? parse_res.n_res : 2'd0;
    assign o_out_valid = q_count != '0;
    assign out_pop     = o_out_valid && !i_out_stall;

    sfr_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (push_n),
        .i_push_item (parse_res.res),
        .i_pop       (out_pop),
        .o_head      (o_out_item),
        .o_count     (q_count)
    );

    `SFR_ASSERT_NOW(a_q_bound, i_clk, i_rst_n, 1'b1, q_count <= CW'(sfr_pkg::OQ_DEPTH), "result queue overflow")
    `SFR_ASSERT_NEXT(a_hdr_queued, i_clk, i_rst_n, in_accept && parse_res.n_res == 2'd3, q_count >= CW'(sfr_pkg::MAX_RES) - CW'(1), "header burst not queued")
    `SFR_ASSERT_NOW(a_run_whole, i_clk, i_rst_n, o_out_valid && !o_out_item.last_of_run, q_count >= CW'(2), "result run split in queue")

endmodule

### verif/serial_frame_router_top_tb.sv
// Self-checking testbench for serial_frame_router_top: directed and random traffic vs predictor.
module serial_frame_router_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PORTS       = 3;
    localparam logic [7:0] RST_SYNC    = 8'd170;
    localparam logic [7:0] RST_MAX_LEN = 8'd64;
    localparam int         SETTLE      = 4;
    localparam int         LONG_HOLD   = 150;
    localparam int         CYCLE_LIMIT = 200000;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               in_valid    = 1'b0;
    logic               o_in_stall;
    sfr_pkg::t_in_item  in_item     = '0;
    logic               o_out_valid;
    logic               out_stall   = 1'b0;
    sfr_pkg::t_out_item o_out_item;
    logic               cfg_we      = 1'b0;
    logic [0:0]         cfg_idx     = sfr_pkg::CFG_SYNC_VALUE;
    logic [7:0]         cfg_data    = '0;

    serial_frame_router_top #(
        .PORT_COUNT(PORTS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // router model state
    logic [7:0]      sync_val = RST_SYNC;
    logic [7:0]      max_len  = RST_MAX_LEN;
    sfr_pkg::t_phase ph   [PORTS];
    logic [1:0]      tgt  [PORTS];
    logic [7:0]      left [PORTS];

    sfr_pkg::t_out_item tx_expect [$];
    sfr_pkg::t_in_item  rx_pending [$];
    sfr_pkg::t_in_item  lane0 [$];
    sfr_pkg::t_in_item  lane1 [$];
    sfr_pkg::t_in_item  lane2 [$];

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_headers   = 0;
    int n_errors    = 0;
    int n_settings  = 1;
    int cycle_cnt   = 0;
    int send_gap    = 0;
    int send_pct    = 0;
    int stall_pct   = 0;
    int stall_run   = 0;
    int hold_left   = 0;
    bit long_hold_req = 1'b0;

    task automatic log_mismatch(string what, logic [7:0] expv, logic [7:0] gotv);
        n_errors++;
        $display("[%0t] mismatch %s: expected %h got %h", $realtime, what, expv, gotv);
    endtask

    function automatic void queue_tx(logic [1:0] dest, logic [7:0] val, logic last);
        sfr_pkg::t_out_item r;
        r.dest_port   = dest;
        r.tx_byte     = val;
        r.last_of_run = last;
        tx_expect.push_back(r);
    endfunction

    // Advances one port parser and queues the bytes it routes.
    function automatic void route_byte(sfr_pkg::t_in_item it);
        int         p;
        logic [7:0] b;
        p = int'(it.source_port);
        b = it.rx_byte;
        if (p >= PORTS)
            return;
        case (ph[p])
            sfr_pkg::PH_SYNC: begin
                if (b == sync_val)
                    ph[p] = sfr_pkg::PH_DEST;
            end
            sfr_pkg::PH_DEST: begin
                if (int'(b) < PORTS && int'(b) != p) begin
                    tgt[p] = b[1:0];
                    ph[p]  = sfr_pkg::PH_LEN;
                end else if (b == sync_val) begin
                    ph[p] = sfr_pkg::PH_DEST;
                end
            end
            sfr_pkg::PH_LEN: begin
                if (b >= 8'd1 && b <= max_len) begin
                    left[p] = b;
                    ph[p]   = sfr_pkg::PH_DATA;
                    n_headers++;
                    queue_tx(tgt[p], sync_val, 1'b0);
                    queue_tx(tgt[p], {6'b0, it.source_port}, 1'b0);
                    queue_tx(tgt[p], b, 1'b1);
                end else if (b == sync_val) begin
                    ph[p] = sfr_pkg::PH_DEST;
                end
            end
            default: begin
                if (b == sync_val) begin
                    ph[p] = sfr_pkg::PH_DEST;
                end else if (b != sfr_pkg::ZERO_CHAR && left[p] != 8'd0) begin
                    left[p] = left[p] - 8'd1;
                    queue_tx(tgt[p], b, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic sfr_pkg::t_in_item mk(int port, int b);
        sfr_pkg::t_in_item it;
        it.source_port = port[1:0];
        it.rx_byte     = b[7:0];
        return it;
    endfunction

    function automatic void enqueue(int port, int b);
        rx_pending.push_back(mk(port, b));
        n_queued++;
    endfunction

    function automatic void lane_push(int p, int b);
        case (p)
            0:       lane0.push_back(mk(p, b));
            1:       lane1.push_back(mk(p, b));
            default: lane2.push_back(mk(p, b));
        endcase
    endfunction

    function automatic int non_sync_byte();
        int b;
        b = $urandom_range(0, 255);
        if (b == int'(sync_val))
            b = b ^ 1;
        return b;
    endfunction

    // One frame for port p: mostly well formed, some cut short or malformed.
    function automatic void build_frame(int p);
        int kind, d, len, n_pay, i, r, cap;
        kind = $urandom_range(0, 99);
        d    = (p + $urandom_range(1, PORTS - 1)) % PORTS;
        lane_push(p, int'(sync_val));
        if (kind < 6)
            return;
        if (kind < 14)
            lane_push(p, $urandom_range(0, 1) ? p : $urandom_range(PORTS, 255));
        lane_push(p, d);
        if (kind < 22) begin
            if (max_len == 8'd255 || $urandom_range(0, 1) == 0)
                lane_push(p, 0);
            else
                lane_push(p, $urandom_range(int'(max_len) + 1, 255));
            return;
        end
        cap = (max_len < 8'd6) ? int'(max_len) : 6;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, int'(max_len))
                                           : $urandom_range(1, cap);
        lane_push(p, len);
        n_pay = (len > 12) ? $urandom_range(3, 12) : len;
        i = 0;
        while (i < n_pay) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                lane_push(p, int'(sfr_pkg::ZERO_CHAR));
            end else if (r < 15 && kind > 90) begin
                // sync mid-payload restarts the frame
                lane_push(p, int'(sync_val));
                return;
            end else begin
                lane_push(p, non_sync_byte());
                i++;
            end
        end
        repeat ($urandom_range(0, 2))
            lane_push(p, non_sync_byte());
    endfunction

    // Interleave per-port frames with noise on any port, including the unused one.
    function automatic void random_phase(int n);
        int start, pick;
        start = n_queued;
        while (n_queued - start < n) begin
            for (int p = 0; p < PORTS; p++)
                if ($urandom_range(0, 3) != 0)
                    build_frame(p);
            while (lane0.size() + lane1.size() + lane2.size() > 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 9) begin
                    enqueue($urandom_range(0, 3), $urandom_range(0, 255));
                end else if (pick < 3 && lane0.size() > 0) begin
                    rx_pending.push_back(lane0.pop_front());
                    n_queued++;
                end else if (pick >= 3 && pick < 6 && lane1.size() > 0) begin
                    rx_pending.push_back(lane1.pop_front());
                    n_queued++;
                end else if (pick >= 6 && lane2.size() > 0) begin
                    rx_pending.push_back(lane2.pop_front());
                    n_queued++;
                end
            end
        end
    endfunction

    task automatic drain_all();
        while (n_accepted != n_queued || tx_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_config(logic [7:0] sv, logic [7:0] ml);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= sfr_pkg::CFG_SYNC_VALUE;
        cfg_data <= sv;
        @(posedge i_clk);
        cfg_idx  <= sfr_pkg::CFG_MAX_LENGTH;
        cfg_data <= ml;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        sync_val = sv;
        max_len  = ml;
        n_settings++;
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_rx
        bit busy;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            busy = in_valid;
            if (in_valid && !o_in_stall) begin
                route_byte(in_item);
                n_accepted++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (rx_pending.size() > 0) begin
                    in_item  <= rx_pending.pop_front();
                    in_valid <= 1'b1;
                    if ($urandom_range(0, 99) < send_pct)
                        send_gap = $urandom_range(1, 8);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall: random bursts plus one long hold on request
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_run > 0) begin
            stall_run--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_run = $urandom_range(0, 7);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin : check_tx
        sfr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            n_results++;
            if (tx_expect.size() == 0) begin
                log_mismatch("unexpected result, byte", 8'h00, o_out_item.tx_byte);
            end else begin
                want = tx_expect.pop_front();
                if (o_out_item.dest_port !== want.dest_port)
                    log_mismatch("dest_port", {6'b0, want.dest_port},
                                 {6'b0, o_out_item.dest_port});
                if (o_out_item.tx_byte !== want.tx_byte)
                    log_mismatch("tx_byte", want.tx_byte, o_out_item.tx_byte);
                if (o_out_item.last_of_run !== want.last_of_run)
                    log_mismatch("last_of_run", {7'b0, want.last_of_run},
                                 {7'b0, o_out_item.last_of_run});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, tx_expect.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        for (int p = 0; p < PORTS; p++) begin
            ph[p]   = sfr_pkg::PH_SYNC;
            tgt[p]  = 2'd0;
            left[p] = 8'd0;
        end
        send_pct  = 15;
        stall_pct = 15;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on the reset settings
        enqueue(3, 170);      // unused port
        enqueue(0, 8'h55);    // noise while hunting for sync
        enqueue(0, 170);
        enqueue(0, 0);        // destination equal to source
        enqueue(0, 3);        // destination out of range
        enqueue(0, 170);      // sync keeps waiting for destination
        enqueue(0, 2);
        enqueue(0, 0);        // zero length
        enqueue(0, 65);       // one past max length
        enqueue(0, 170);      // sync in length phase
        enqueue(0, 1);
        enqueue(0, 2);        // header to port 1
        enqueue(0, int'(sfr_pkg::ZERO_CHAR));
        enqueue(0, 255);
        enqueue(0, 0);        // count now spent
        enqueue(0, 8'h41);    // discarded
        enqueue(1, 170);
        enqueue(1, 0);
        enqueue(1, 64);       // max length
        enqueue(1, 8'h7E);
        enqueue(1, 170);      // sync inside payload restarts
        enqueue(2, 170);
        enqueue(2, 1);
        enqueue(2, 1);
        enqueue(2, 8'hC3);
        drain_all();

        // long receiver hold while the sender keeps offering requests
        write_config(8'd255, 8'd255);
        send_pct  = 30;
        stall_pct = 30;
        long_hold_req = 1'b1;
        random_phase(80);
        drain_all();

        write_config(8'd0, 8'd1);
        send_pct  = 10;
        stall_pct = 5;
        random_phase(60);
        drain_all();

        // sync below the port count: port test wins over sync test
        write_config(8'd1, 8'd3);
        send_pct  = 40;
        stall_pct = 40;
        random_phase(60);
        drain_all();

        write_config(sfr_pkg::ZERO_CHAR, 8'd200);
        send_pct  = 20;
        stall_pct = 0;
        random_phase(60);
        drain_all();

        // back to reset values, full rate both sides
        write_config(RST_SYNC, RST_MAX_LEN);
        send_pct  = 0;
        stall_pct = 0;
        random_phase(70);
        drain_all();

        $display("covered %0d requests, %0d routed bytes (%0d headers) over %0d settings",
                 n_accepted, n_results, n_headers, n_settings);
        $display("settings spanned sync 0..255 and max length 1..255, %0d cycles",
                 cycle_cnt);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/sfr_pkg.sv
design/sfr_parse.sv
design/sfr_outq.sv
design/serial_frame_router_top.sv
verif/serial_frame_router_top_tb.sv
